// ===== hw/rtl/stfs_pkg.sv =====
// shared widths, defaults and control/status types of the sorted table floor search
package stfs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_ADDR_BITS   = 48;

    localparam int SLOT_W  = 10;  // slot field of a write beat
    localparam int INDEX_W = 10;  // entry index field of a result beat
    localparam int COUNT_W = 11;  // entries_in_use register

    // controller to datapath
    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic in_last;   // fetching the last in-use entry
        logic in_probe;  // issuing the first bisection probe
        logic in_step;   // evaluating one bisection probe
        logic finish;    // load the result register
    } stfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lookup;    // current input beat is a lookup
        logic empty;     // no entries in use
        logic done;      // bisection range closes this step
        logic out_free;  // result register can take a new result
    } stfs_status_t;

endpackage

// ===== hw/rtl/sorted_table_floor_search.sv =====
// top level of the sorted table floor search: streaming ports, controller and datapath
//
// usage:
//   input beats (s_ side): s_tuser selects the command, 0 = write the address in
//   s_tdata into the given slot, 1 = look the address up. writes to slots at or
//   above TABLE_DEPTH are dropped. a write produces no output beat.
//   output beats (m_ side): one per lookup, with the index of the last entry at or
//   below the query, the signed offset from it and the exact/span flags.
//   cfg_wr_en/cfg_wr_data set entries_in_use; write it only while the block is idle.
//   a write is stored in the table at the edge that accepts its beat. a lookup runs
//   from the accepted beat to m_tvalid through a fetch of the last entry, a first probe,
//   the bisection over n, the clamped entry count, at one probe per cycle on the
//   one-read-per-cycle table port, and a result cycle; an empty table goes right to it.
//   one lookup is in flight at a time; s_tready returns at the same edge that loads
//   the result into the output register.
//   stall: a result waits in the output register while m_tready is low; the next
//   beat is still taken and a following lookup parks in its result cycle.
//   reset: clears entries_in_use to 0 and drops any pending result; table contents
//   stay undefined until written.
module sorted_table_floor_search #(
    parameter int TABLE_DEPTH = stfs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_BITS   = stfs_pkg::DEFAULT_ADDR_BITS,
    parameter int IN_DATA_W   = ((stfs_pkg::SLOT_W + ADDR_BITS + 7) / 8) * 8,
    parameter int OUT_DATA_W  = ((stfs_pkg::INDEX_W + ADDR_BITS + 3 + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [stfs_pkg::COUNT_W-1:0] cfg_wr_data,  // entries_in_use
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [IN_DATA_W-1:0]         s_tdata,      // entry_slot, address, zero pad
    input  logic                         s_tuser,      // cmd
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [OUT_DATA_W-1:0]        m_tdata,      // entry_index, offset, exact_hit,
                                                       // within_span, zero pad
    output logic                         m_tuser       // table_present
);
    import stfs_pkg::*;

    stfs_cmd_t            cmd;
    stfs_status_t         status;
    logic [SLOT_W-1:0]    in_slot;
    logic [ADDR_BITS-1:0] in_address;
    logic [INDEX_W-1:0]   out_entry_index;
    logic [ADDR_BITS:0]   out_offset;
    logic                 out_exact_hit;
    logic                 out_within_span;

    // unpack the input beat
    assign in_slot    = s_tdata[SLOT_W-1:0];
    assign in_address = s_tdata[SLOT_W +: ADDR_BITS];

    stfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stfs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_lookup         (s_tuser),
        .in_slot           (in_slot),
        .in_address        (in_address),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_table_present (m_tuser),
        .out_entry_index   (out_entry_index),
        .out_offset        (out_offset),
        .out_exact_hit     (out_exact_hit),
        .out_within_span   (out_within_span)
    );

    // pack the result beat, lowest field first, zero padded to whole bytes
    assign m_tdata = OUT_DATA_W'({out_within_span, out_exact_hit, out_offset, out_entry_index});

endmodule

// ===== hw/rtl/stfs_table_ram.sv =====
// single-port-write, single-port-read table memory with registered read data
module stfs_table_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/stfs_ctrl.sv =====
// sequencer for table writes and bisection lookups
module stfs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  stfs_pkg::stfs_status_t status,
    output stfs_pkg::stfs_cmd_t    cmd
);
    import stfs_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LAST   = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && status.lookup) begin
                    state_next = status.empty ? ST_FINISH : ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (status.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.in_last  = (state_reg == ST_LAST);
        cmd.in_probe = (state_reg == ST_PROBE);
        cmd.in_step  = (state_reg == ST_STEP);
        cmd.finish   = (state_reg == ST_FINISH) && status.out_free;
    end

`ifndef ASSERT_OFF
    a_last_then_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LAST) |=> (state_reg == ST_PROBE))
        else $error("last-entry fetch not followed by first probe");

    a_finish_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && !status.out_free) |=> (state_reg == ST_FINISH))
        else $error("result dropped while output stalled");
`endif

endmodule

// ===== hw/rtl/stfs_datapath.sv =====
// table storage, bisection registers, result computation and result register
module stfs_datapath #(
    parameter int TABLE_DEPTH = stfs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_BITS   = stfs_pkg::DEFAULT_ADDR_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [stfs_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic                          in_lookup,
    input  logic [stfs_pkg::SLOT_W-1:0]   in_slot,
    input  logic [ADDR_BITS-1:0]          in_address,
    input  stfs_pkg::stfs_cmd_t           cmd,
    output stfs_pkg::stfs_status_t        status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_table_present,
    output logic [stfs_pkg::INDEX_W-1:0]  out_entry_index,
    output logic [ADDR_BITS:0]            out_offset,
    output logic                          out_exact_hit,
    output logic                          out_within_span
);
    import stfs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    logic [COUNT_W-1:0]   cfg_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     len_reg;
    logic [IDX_W-1:0]     mid_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic                 first_le_reg;
    logic                 last_ge_reg;
    logic                 empty_reg;

    logic                 valid_reg;
    logic                 present_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic [ADDR_BITS:0]   offset_reg;
    logic                 exact_reg;
    logic                 span_reg;

    logic [CNT_W-1:0]     n_next;
    logic [CNT_W-1:0]     n_minus1;
    logic [CNT_W-1:0]     half;
    logic [CNT_W-1:0]     lo_next;
    logic [CNT_W-1:0]     len_next;
    logic [CNT_W-1:0]     mid_next;
    logic [IDX_W-1:0]     rd_addr;
    logic [ADDR_BITS-1:0] rd_data;
    logic                 le;
    logic                 wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // clamp the count to the table depth
    assign n_next = (32'(cfg_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg_reg);

    assign wr_en = cmd.accept && !in_lookup && (32'(in_slot) < 32'(TABLE_DEPTH));

    stfs_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ADDR_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(in_slot)),
        .wr_data (in_address),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one bisection step on the entry read at mid_reg
    assign le       = (rd_data <= addr_reg);
    assign half     = len_reg >> 1;
    assign lo_next  = le ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
    assign len_next = le ? (len_reg - half - CNT_W'(1)) : half;
    assign mid_next = lo_next + (len_next >> 1);
    assign n_minus1 = n_reg - CNT_W'(1);

    // idle reads slot 0, so entry 0 is ready in the first cycle after a lookup beat
    always_comb begin
        rd_addr = '0;
        if (cmd.in_last) begin
            rd_addr = n_minus1[IDX_W-1:0];
        end else if (cmd.in_probe) begin
            rd_addr = mid_reg;
        end else if (cmd.in_step) begin
            rd_addr = mid_next[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg  <= in_address;
            n_reg     <= n_next;
            empty_reg <= (cfg_reg == '0);
        end
        if (cmd.in_last) begin
            // rd_data holds entry 0 here
            first_le_reg <= le;
            base_reg     <= rd_data;
            pick_reg     <= '0;
            lo_reg       <= '0;
            len_reg      <= n_reg;
            mid_reg      <= IDX_W'(n_reg >> 1);
        end
        if (cmd.in_probe) begin
            // rd_data holds the last in-use entry here
            last_ge_reg <= (addr_reg <= rd_data);
        end
        if (cmd.in_step) begin
            lo_reg  <= lo_next;
            len_reg <= len_next;
            mid_reg <= mid_next[IDX_W-1:0];
            if (le) begin
                base_reg <= rd_data;
                pick_reg <= mid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (empty_reg) begin
                present_reg <= 1'b0;
                index_reg   <= '0;
                offset_reg  <= '0;
                exact_reg   <= 1'b0;
                span_reg    <= 1'b0;
            end else begin
                present_reg <= 1'b1;
                index_reg   <= INDEX_W'(pick_reg);
                offset_reg  <= {1'b0, addr_reg} - {1'b0, base_reg};
                exact_reg   <= (addr_reg == base_reg);
                span_reg    <= first_le_reg && last_ge_reg;
            end
        end
    end

    assign status.lookup   = in_lookup;
    assign status.empty    = (cfg_reg == '0);
    assign status.done     = (len_next == '0);
    assign status.out_free = !valid_reg || out_ready;

    assign out_valid         = valid_reg;
    assign out_table_present = present_reg;
    assign out_entry_index   = index_reg;
    assign out_offset        = offset_reg;
    assign out_exact_hit     = exact_reg;
    assign out_within_span   = span_reg;

`ifndef ASSERT_OFF
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.in_step |-> (len_reg != '0) && (CNT_W'(mid_reg) < n_reg))
        else $error("bisection probe outside the in-use entries");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!valid_reg || out_ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule
